// File: hw/rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int BOARD_WIDTH  = 256;
  localparam int BOARD_HEIGHT = 256;
  // The board size must be a power of two. Address wrap and the reduction of
  // start and load addresses are then plain truncation.
  localparam int BOARD_CELLS  = BOARD_WIDTH * BOARD_HEIGHT;
  localparam int POS_W        = $clog2(BOARD_CELLS);
  localparam int BYTE_DEPTH   = BOARD_CELLS / 8;
  localparam int BYTE_AW      = $clog2(BYTE_DEPTH);

  localparam int RULES_W    = 40;
  localparam int RULE_W     = 5;
  localparam int START_W    = 16;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RULES_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RULES_ONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ZERO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ONE  = 2'd3;

  localparam logic [1:0] MODE_STEP    = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [1:0] DIR_SOUTH = 2'd0;
  localparam logic [1:0] DIR_WEST  = 2'd1;
  localparam logic [1:0] DIR_NORTH = 2'd2;
  localparam logic [1:0] DIR_EAST  = 2'd3;

  localparam logic [START_W-1:0] START_ZERO_RST = 16'd15420;
  localparam logic [START_W-1:0] START_ONE_RST  = 16'd41120;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } tcw_state_t;

  localparam logic [POS_W:0] CELLS_X = (POS_W+1)'(BOARD_CELLS);
  localparam logic [POS_W:0] WIDTH_X = (POS_W+1)'(BOARD_WIDTH);
  localparam pos_t           LAST_POS = POS_W'(BOARD_CELLS - 1);

  function automatic pos_t tcw_move(input pos_t pos, input logic [1:0] dir);
    logic [POS_W:0] sum;
    pos_t           res;
    sum = '0;
    case (dir)
      DIR_SOUTH: begin
        sum = {1'b0, pos} + WIDTH_X;
        if (sum >= CELLS_X) sum = sum - CELLS_X;
        res = sum[POS_W-1:0];
      end
      DIR_WEST: begin
        res = (pos == '0) ? LAST_POS : pos - pos_t'(1);
      end
      DIR_NORTH: begin
        sum = {1'b0, pos} + CELLS_X - WIDTH_X;
        if (sum >= CELLS_X) sum = sum - CELLS_X;
        res = sum[POS_W-1:0];
      end
      default: begin
        res = (pos == LAST_POS) ? '0 : pos + pos_t'(1);
      end
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/tcw_if.sv
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        walker;
  logic [3:0]  shade;
  logic [12:0] load_addr;
  logic [7:0]  load_bits;

  modport source(output valid, mode, walker, shade, load_addr, load_bits, input ready);
  modport sink(input valid, mode, walker, shade, load_addr, load_bits, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_addr;
  logic [3:0]  pixel_color;
  logic        cell_color;

  modport source(output valid, pixel_addr, pixel_color, cell_color, input ready);
  modport sink(input valid, pixel_addr, pixel_color, cell_color, output ready);
endinterface

// File: hw/rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/two_color_turmite_walker_unit.sv
// A step reads the board byte in the accept cycle; once the output register can
// take the result word, the byte is written back and the result word registered.
// Load and restart words are handled in the idle state. No new word is accepted
// while a step waits for its write-back. Synchronous active-low reset clears
// control and rules and sets walker state and start addresses to their reset
// values; the board memory is not cleared and must be loaded before use.
module two_color_turmite_walker_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  tcw_in_if.sink                         in_ch,
  tcw_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tcw_pkg::*;

  tcw_state_t state_r, state_nxt;

  logic [RULES_W-1:0] rules0_r, rules1_r;
  logic [START_W-1:0] start0_r, start1_r;

  pos_t       pos_r [2];
  logic [1:0] dir_r [2];
  logic [1:0] wst_r [2];

  logic       w_r;
  logic [3:0] shade_r;

  logic        out_valid_r;
  logic [15:0] out_addr_r;
  logic [3:0]  out_color_r;
  logic        out_cell_r;

  logic               in_fire, out_free, exec_go;
  logic               ram_we, ram_re;
  logic [BYTE_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  pos_t               cur_pos, new_pos, restart_pos;
  logic [2:0]         bsel;
  logic               col;
  logic [2:0]         ridx;
  logic [5:0]         roff;
  logic [RULES_W-1:0] rules_sel;
  logic [RULE_W-1:0]  rule;
  logic [1:0]         new_dir;
  logic [7:0]         new_byte;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Step datapath, active while the read byte sits in the memory output.
  always_comb begin
    cur_pos   = pos_r[w_r];
    // The most significant bit of a byte holds the lowest cell address.
    bsel      = ~cur_pos[2:0];
    col       = ram_rdata[bsel];
    ridx      = {wst_r[w_r], col};
    roff      = 6'(ridx) * 6'd5;
    rules_sel = w_r ? rules1_r : rules0_r;
    rule      = rules_sel[roff +: RULE_W];
    new_dir   = dir_r[w_r] + rule[2:1];
    new_pos   = tcw_move(cur_pos, new_dir);
    new_byte  = ram_rdata;
    new_byte[bsel] = rule[0];
    restart_pos = in_ch.walker ? POS_W'(start1_r) : POS_W'(start0_r);
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    exec_go     = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = pos_r[in_ch.walker][POS_W-1:3];
    ram_waddr   = BYTE_AW'(in_ch.load_addr);
    ram_wdata   = in_ch.load_bits;
    case (state_r)
      ST_IDLE: begin
        // No word is taken while reset is held.
        in_ch.ready = rst_n;
        if (rst_n && in_ch.valid && in_ch.mode == MODE_STEP) begin
          ram_re    = 1'b1;
          state_nxt = ST_EXEC;
        end
        if (rst_n && in_ch.valid && in_ch.mode == MODE_LOAD) ram_we = 1'b1;
      end
      ST_EXEC: begin
        // Hold the read byte until the output register can take the result.
        if (out_free) begin
          exec_go   = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = cur_pos[POS_W-1:3];
          ram_wdata = new_byte;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rules0_r <= '0;
      rules1_r <= '0;
      start0_r <= START_ZERO_RST;
      start1_r <= START_ONE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RULES_ZERO: rules0_r <= cfg_wdata[RULES_W-1:0];
        CFG_RULES_ONE:  rules1_r <= cfg_wdata[RULES_W-1:0];
        CFG_START_ZERO: start0_r <= cfg_wdata[START_W-1:0];
        CFG_START_ONE:  start1_r <= cfg_wdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r[0] <= POS_W'(START_ZERO_RST);
      pos_r[1] <= POS_W'(START_ONE_RST);
      dir_r[0] <= DIR_SOUTH;
      dir_r[1] <= DIR_SOUTH;
      wst_r[0] <= '0;
      wst_r[1] <= '0;
    end else if (exec_go) begin
      pos_r[w_r] <= new_pos;
      dir_r[w_r] <= new_dir;
      wst_r[w_r] <= rule[4:3];
    end else if (in_fire && in_ch.mode == MODE_RESTART) begin
      pos_r[in_ch.walker] <= restart_pos;
      dir_r[in_ch.walker] <= DIR_SOUTH;
      wst_r[in_ch.walker] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      w_r     <= in_ch.walker;
      shade_r <= in_ch.shade;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_addr_r  <= 16'(cur_pos);
      out_color_r <= shade_r;
      out_cell_r  <= rule[0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_addr  = out_addr_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.cell_color  = out_cell_r;

  tcw_ram #(
    .WIDTH(8),
    .DEPTH(BYTE_DEPTH)
  ) u_board (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

// File: hw/rtl/tcw_checker.sv
module tcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pixel_addr,
  input logic        out_cell_color
);
  import tcw_pkg::*;

  // A step occupies the board memory for its write-back cycle.
  a_step_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_STEP |=> !in_ready)
    else $error("word accepted during step write-back");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode != MODE_STEP && !out_valid |=> !out_valid)
    else $error("result word without a step");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_addr) && $stable(out_cell_color))
    else $error("result word changed while stalled");

endmodule

bind two_color_turmite_walker_unit tcw_checker u_tcw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_mode       (in_ch.mode),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_pixel_addr(out_ch.pixel_addr),
  .out_cell_color(out_ch.cell_color)
);

// File: dv/testbench.sv
module testbench;
  import tcw_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_WORDS   = 250;
  localparam int NUM_PHASES    = 7;
  localparam int RUN_LIMIT     = 20_000_000;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [RULES_W-1:0] RULES_ALL_ONES = '1;
  // Every rule keeps state zero, turns a quarter to the west and paints the cell.
  localparam logic [RULES_W-1:0] RULES_WEST = {8{5'b00011}};

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] =
    '{CFG_RULES_ZERO, CFG_RULES_ONE, CFG_START_ZERO, CFG_START_ONE};

  typedef struct packed {
    logic [1:0]  mode;
    logic        walker;
    logic [3:0]  shade;
    logic [12:0] load_addr;
    logic [7:0]  load_bits;
  } word_t;

  typedef struct packed {
    pos_t       addr;
    logic [3:0] color;
    logic       cell_bit;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  two_color_turmite_walker_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Board and walker state as the block should hold it.
  bit                 board_bit   [BOARD_CELLS];
  bit                 board_known [BOARD_CELLS];
  pos_t               ant_pos     [2];
  logic [1:0]         ant_dir     [2];
  logic [1:0]         ant_state   [2];
  logic [RULES_W-1:0] ant_rules   [2];
  logic [START_W-1:0] ant_start   [2];

  pixel_t pixels_due[$];
  int     pixel_errors = 0;
  int     burst_left = 0;
  bit     long_hold_req = 1'b0;

  function automatic logic [CFG_DATA_W-1:0] rand_wide();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  function automatic word_t load_word(input logic [12:0] addr, input logic [7:0] bits);
    word_t wd;
    wd = '{mode: MODE_LOAD, walker: 1'($urandom), shade: 4'($urandom),
           load_addr: addr, load_bits: bits};
    return wd;
  endfunction

  function automatic void apply_word(input word_t wd);
    int         spot;
    int         nxt;
    logic [2:0] idx;
    logic [4:0] rule_bits;
    pixel_t     px;
    case (wd.mode)
      MODE_LOAD: begin
        for (int j = 0; j < 8; j++) begin
          spot = (int'(wd.load_addr) * 8 + j) % BOARD_CELLS;
          board_bit[spot]   = wd.load_bits[7 - j];
          board_known[spot] = 1'b1;
        end
      end
      MODE_RESTART: begin
        ant_pos[wd.walker]   = pos_t'(int'(ant_start[wd.walker]) % BOARD_CELLS);
        ant_dir[wd.walker]   = DIR_SOUTH;
        ant_state[wd.walker] = 2'd0;
      end
      MODE_STEP: begin
        spot      = int'(ant_pos[wd.walker]);
        idx       = {ant_state[wd.walker], board_bit[spot]};
        rule_bits = ant_rules[wd.walker][int'(idx) * RULE_W +: RULE_W];
        ant_state[wd.walker] = rule_bits[4:3];
        ant_dir[wd.walker]   = ant_dir[wd.walker] + rule_bits[2:1];
        board_bit[spot]      = rule_bits[0];
        board_known[spot]    = 1'b1;
        px.addr     = pos_t'(spot);
        px.color    = wd.shade;
        px.cell_bit = rule_bits[0];
        pixels_due.push_back(px);
        case (ant_dir[wd.walker])
          DIR_SOUTH: nxt = spot + BOARD_WIDTH;
          DIR_WEST:  nxt = spot + BOARD_CELLS - 1;
          DIR_NORTH: nxt = spot + BOARD_CELLS - BOARD_WIDTH;
          default:   nxt = spot + 1;
        endcase
        ant_pos[wd.walker] = pos_t'(nxt % BOARD_CELLS);
      end
      default: ;
    endcase
  endfunction

  // The sender offers words in bursts; valid stays high across a burst.
  task automatic send_word(input word_t wd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= wd.mode;
    in_ch.walker    <= wd.walker;
    in_ch.shade     <= wd.shade;
    in_ch.load_addr <= wd.load_addr;
    in_ch.load_bits <= wd.load_bits;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    apply_word(wd);
  endtask

  // Loads the byte under the walker first if that cell was never written.
  task automatic step_walker(input logic w, input logic [3:0] shade);
    word_t wd;
    pos_t  p;
    p = ant_pos[w];
    if (!board_known[p])
      send_word(load_word(p[POS_W-1:3], 8'($urandom)));
    wd = '{mode: MODE_STEP, walker: w, shade: shade,
           load_addr: 13'($urandom), load_bits: 8'($urandom)};
    send_word(wd);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pixels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [3:0] sel, input logic [CFG_DATA_W-1:0] r0,
                            input logic [CFG_DATA_W-1:0] r1,
                            input logic [CFG_DATA_W-1:0] s0,
                            input logic [CFG_DATA_W-1:0] s1);
    logic [CFG_DATA_W-1:0] vals [4];
    vals = '{r0, r1, s0, s1};
    for (int k = 0; k < 4; k++) begin
      if (sel[k]) begin
        cfg_we    <= 1'b1;
        cfg_index <= REG_ORDER[k];
        cfg_wdata <= vals[k];
        @(posedge clk);
        case (REG_ORDER[k])
          CFG_RULES_ZERO: ant_rules[0] = vals[k][RULES_W-1:0];
          CFG_RULES_ONE:  ant_rules[1] = vals[k][RULES_W-1:0];
          CFG_START_ZERO: ant_start[0] = vals[k][START_W-1:0];
          default:        ant_start[1] = vals[k][START_W-1:0];
        endcase
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic flag_pixel(input string msg);
    $display("pixel mismatch at %0t: %s", $realtime, msg);
    pixel_errors++;
  endtask

  task automatic test_directed_corners();
    word_t wd;
    wd = '{mode: MODE_UNUSED, walker: 1'b1, shade: 4'hF, load_addr: 13'h1FFF,
           load_bits: 8'hFF};
    send_word(wd);
    send_word(load_word(13'h0000, 8'hFF));
    send_word(load_word(13'h1FFF, 8'h00));
    send_word(load_word(13'h0AAA, 8'h5A));
    step_walker(1'b0, 4'h0);
    step_walker(1'b0, 4'hF);
    step_walker(1'b1, 4'hF);
    step_walker(1'b1, 4'h0);
    wd = '{mode: MODE_RESTART, walker: 1'b0, shade: 4'h0, load_addr: 13'h0000,
           load_bits: 8'h00};
    send_word(wd);
    wd = '{mode: MODE_RESTART, walker: 1'b1, shade: 4'hF, load_addr: 13'h1FFF,
           load_bits: 8'hFF};
    send_word(wd);
    step_walker(1'b0, 4'h5);
    step_walker(1'b1, 4'hA);
  endtask

  // Walker zero starts at the first cell turning west each step, walker one at the
  // last cell turning east, so together they cross every edge of the board.
  task automatic test_board_wrap();
    word_t wd;
    wait_drained();
    write_regs(4'hF, RULES_WEST, RULES_ALL_ONES, '0, '1);
    // A new start address must not move the walker before it is restarted.
    step_walker(1'b0, 4'h3);
    for (int k = 0; k < 2; k++) begin
      wd = '{mode: MODE_RESTART, walker: k[0], shade: 4'($urandom),
             load_addr: 13'($urandom), load_bits: 8'($urandom)};
      send_word(wd);
    end
    for (int k = 0; k < 4; k++) begin
      step_walker(1'b0, 4'(k));
      step_walker(1'b1, 4'(k + 8));
    end
  endtask

  task automatic test_random_walk();
    logic [CFG_DATA_W-1:0] r0, r1, s0, s1;
    logic [3:0]            sel;
    int                    sent;
    int                    pick;
    logic                  w;
    word_t                 wd;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      r0  = rand_wide();
      r1  = rand_wide();
      s0  = rand_wide();
      s1  = rand_wide();
      sel = 4'($urandom_range(1, 15));
      if (ph == 0) begin
        r0 = RULES_ALL_ONES;
        r1 = '0;
        s0 = '0;
        s1 = 40'h00_0000_FFFF;
        sel = 4'hF;
      end else if (ph == 1) begin
        r0 = '0;
        r1 = RULES_ALL_ONES;
        s0 = '1;
        s1 = 40'hFF_FFFF_0000;
        sel = 4'hF;
      end else if (ph == 2) begin
        sel = 4'hF;
      end
      write_regs(sel, r0, r1, s0, s1);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        w    = 1'($urandom);
        if (pick < 66) begin
          step_walker(w, 4'($urandom));
          sent++;
        end else if (pick < 76) begin
          send_word(load_word(13'($urandom), 8'($urandom)));
          sent++;
        end else if (pick < 84) begin
          // Rewrite the byte a walker is on or next to, right behind its accesses.
          send_word(load_word(13'(int'(ant_pos[w][POS_W-1:3]) + $urandom_range(0, 2) - 1),
                              8'($urandom)));
          sent++;
        end else if (pick < 92) begin
          wd = '{mode: MODE_RESTART, walker: w, shade: 4'($urandom),
                 load_addr: 13'($urandom), load_bits: 8'($urandom)};
          send_word(wd);
          sent++;
        end else if (pick < 97) begin
          wd = '{mode: MODE_UNUSED, walker: w, shade: 4'($urandom),
                 load_addr: 13'($urandom), load_bits: 8'($urandom)};
          send_word(wd);
        end else begin
          wait_drained();
        end
      end
    end
  endtask

  // The receiver holds off for a long time while steps keep coming, so the
  // block has to stall its input.
  task automatic test_stall_recovery();
    long_hold_req = 1'b1;
    for (int k = 0; k < 40; k++)
      step_walker(k[0], 4'($urandom));
    wait_drained();
  endtask

  initial begin : receiver
    int stall_kind;
    int kind_left;
    int tick;
    stall_kind = 0;
    kind_left  = 0;
    tick       = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (kind_left == 0) begin
        stall_kind = $urandom_range(0, 3);
        kind_left  = $urandom_range(20, 200);
      end
      kind_left--;
      tick++;
      case (stall_kind)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 99) >= 30);
        2:       out_ch.ready <= ($urandom_range(0, 99) >= 80);
        default: out_ch.ready <= ((tick % 5) < 3);
      endcase
    end
  end

  always @(posedge clk) begin : pixel_checker
    pixel_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pixels_due.size() == 0) begin
        flag_pixel($sformatf("word with no pending pixel, addr %0d", out_ch.pixel_addr));
      end else begin
        want = pixels_due.pop_front();
        if (out_ch.pixel_addr !== want.addr)
          flag_pixel($sformatf("pixel_addr %0d, want %0d", out_ch.pixel_addr, want.addr));
        if (out_ch.pixel_color !== want.color)
          flag_pixel($sformatf("pixel_color %0d at %0d, want %0d", out_ch.pixel_color,
                               want.addr, want.color));
        if (out_ch.cell_color !== want.cell_bit)
          flag_pixel($sformatf("cell_color %0b at %0d, want %0b", out_ch.cell_color,
                               want.addr, want.cell_bit));
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_RULES_ZERO;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_STEP;
    in_ch.walker    <= 1'b0;
    in_ch.shade     <= 4'h0;
    in_ch.load_addr <= 13'h0000;
    in_ch.load_bits <= 8'h00;
    ant_rules[0] = '0;
    ant_rules[1] = '0;
    ant_start[0] = START_ZERO_RST;
    ant_start[1] = START_ONE_RST;
    for (int k = 0; k < 2; k++) begin
      ant_pos[k]   = pos_t'(int'(ant_start[k]) % BOARD_CELLS);
      ant_dir[k]   = DIR_SOUTH;
      ant_state[k] = 2'd0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_board_wrap();
    test_random_walk();
    test_stall_recovery();
    wait_drained();
    if (pixel_errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
